// ===== hw/rtl/bbw_pkg.sv =====
// shared types and constants of the box blur window unit
// no dependencies

package bbw_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_WINDOW = 5;

	localparam int PIX_W     = 8;
	localparam int POS_W     = 12;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam int SMALL_K = 3;
	localparam int BIG_K   = 5;

	localparam int MIN_SIZE   = 5;
	localparam int RESET_SIZE = 1024;

	// column sum of up to five pixels, window sum of up to 25
	localparam int CS_W  = 11;
	localparam int SUM_W = 13;

	// floor(s / 9) and floor(s / 25) as (s * recip) >> 20, exact for s <= 6375
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP9  = RECIP_W'(116509);
	localparam logic [RECIP_W-1:0] RECIP25 = RECIP_W'(41944);

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH     = 2'd0,
		REG_LINE_COUNT     = 2'd1,
		REG_WINDOW_IS_FIVE = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             frame_start;
	} pixel_t;

	typedef struct packed {
		logic [PIX_W-1:0] blurred;
		logic [POS_W-1:0] centre_col;
		logic [POS_W-1:0] centre_row;
		logic             frame_end;
	} result_t;

	typedef struct packed {
		logic [CS_W-1:0]  sum3;
		logic [CS_W-1:0]  sum_max;
		logic             k5;
		logic             emit;
		logic [POS_W-1:0] centre_col;
		logic [POS_W-1:0] centre_row;
		logic             frame_end;
	} col_item_t;

endpackage

// ===== hw/rtl/box_blur_window_unit.sv =====
// top level of the box blur window unit
// depends on bbw_pkg, bbw_front, bbw_fifo, bbw_back
//
// Usage:
// Pixels come in raster order through a queue-like port: a beat is taken on
// a clock edge with push high and full low. Results leave through a second
// queue-like port: the oldest result sits on result while empty is low and
// is taken on an edge with pop high. Only interior window centres give a
// result; border pixels give none. Registers are written through cfg_wr_en,
// cfg_index and cfg_data while no pixel is in flight.
// Throughput is one pixel per clock while full stays low. A pixel's result
// passes stage one, the column queue, the window stage, the sum stage and
// then the output queue before it shows on the result port.
// When the receiver stalls, the output queue and a four-entry column queue
// fill; full rises once both are full and stage one holds its pixel.
// Reset clears counters, window and queues and loads a 1024 x 1024 frame
// with a 5x5 box; the line store holds no data until rows are written.

module box_blur_window_unit import bbw_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  pixel_t               pixel,
	output logic                 empty,
	input  logic                 pop,
	output result_t              result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic                         mid_push;
	logic                         mid_full;
	logic                         mid_empty;
	logic                         mid_pop;
	col_item_t                    mid_wr;
	logic [$bits(col_item_t)-1:0] mid_rd_bits;
	logic                         out_push;
	result_t                      out_item;
	logic [LVL_W-1:0]             out_level;
	logic [$bits(result_t)-1:0]   out_rd_bits;

	bbw_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mid_push  (mid_push),
		.mid_item  (mid_wr),
		.mid_full  (mid_full)
	);

	bbw_fifo #(
		.WIDTH ($bits(col_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.full   (mid_full),
		.wdata  (mid_wr),
		.pop    (mid_pop),
		.empty  (mid_empty),
		.rdata  (mid_rd_bits),
		.level  ()
	);

	bbw_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_item  (col_item_t'(mid_rd_bits)),
		.mid_pop   (mid_pop),
		.out_level (out_level),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	bbw_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (),
		.wdata  (out_item),
		.pop    (pop),
		.empty  (empty),
		.rdata  (out_rd_bits),
		.level  (out_level)
	);

	assign result = result_t'(out_rd_bits);

endmodule

// ===== hw/rtl/bbw_fifo.sv =====
// small first-in first-out queue of flat words, depth a power of two
// depends on nothing

module bbw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic                       empty,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int PW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/bbw_front.sv =====
// front end: configuration registers, position counters, line store and column sums
// depends on bbw_pkg

module bbw_front import bbw_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  pixel_t               pixel,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 mid_push,
	output col_item_t            mid_item,
	input  logic                 mid_full
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int HIST  = MAX_WINDOW - 1;
	localparam int LS_W  = HIST * PIX_W;
	localparam int CFG_X = CFG_W + 1;

	logic [CFG_W-1:0] line_width_q;
	logic [CFG_W-1:0] line_count_q;
	logic             win5_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;

	logic [CFG_X-1:0] lw_ext;
	logic [CFG_X-1:0] lc_ext;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;

	logic             accept;
	logic             s1_go;
	logic             k5;
	logic [CW-1:0]    c0;
	logic [RW-1:0]    r0;
	logic             wrap_c;
	logic [HW-1:0]    r_mid;
	logic [CW-1:0]    c_cur;
	logic [RW-1:0]    r_cur;
	logic [CW-1:0]    c_diff;
	logic [RW-1:0]    r_diff;
	logic [CW+POS_W-1:0] ccol_ext;
	logic [RW+POS_W-1:0] crow_ext;
	logic             emit;
	logic             fend;
	logic [WW-1:0]    c_next;
	logic [HW-1:0]    r_next;

	logic [LS_W-1:0]  line_mem [MAX_WIDTH];

	logic             s1_valid_q;
	logic             hit_s1;
	logic [LS_W-1:0]  fwd_s1;
	logic [LS_W-1:0]  rd_s1;
	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0]    col_s1;
	logic             k5_s1;
	logic             emit_s1;
	logic [POS_W-1:0] ccol_s1;
	logic [POS_W-1:0] crow_s1;
	logic             fend_s1;

	logic [LS_W-1:0]  hist;
	logic [LS_W-1:0]  hist_new;
	logic [CS_W-1:0]  cs3;
	logic [CS_W-1:0]  csm;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= CFG_W'(RESET_SIZE);
			line_count_q <= CFG_W'(RESET_SIZE);
			win5_q       <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:     line_width_q <= cfg_data;
				REG_LINE_COUNT:     line_count_q <= cfg_data;
				REG_WINDOW_IS_FIVE: win5_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped frame size
	always_comb begin
		lw_ext = {1'b0, line_width_q};
		lc_ext = {1'b0, line_count_q};
		if (lw_ext < CFG_X'(MIN_SIZE)) begin
			w = WW'(MIN_SIZE);
		end else if (lw_ext > CFG_X'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(lw_ext);
		end
		if (lc_ext < CFG_X'(MIN_SIZE)) begin
			h = HW'(MIN_SIZE);
		end else if (lc_ext > CFG_X'(MAX_HEIGHT)) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(lc_ext);
		end
	end

	assign s1_go  = s1_valid_q && !mid_full;
	assign full   = s1_valid_q && mid_full;
	assign accept = push && !full;

	// position of the incoming pixel and of the next one
	always_comb begin
		k5     = win5_q && (MAX_WINDOW >= BIG_K);
		c0     = pixel.frame_start ? '0 : col_q;
		r0     = pixel.frame_start ? '0 : row_q;
		wrap_c = (WW'(c0) >= w);
		r_mid  = wrap_c ? HW'(r0) + HW'(1) : HW'(r0);
		c_cur  = wrap_c ? '0 : c0;
		r_cur  = (r_mid >= h) ? '0 : RW'(r_mid);
		emit   = (c_cur >= CW'(k5 ? BIG_K - 1 : SMALL_K - 1)) &&
		         (r_cur >= RW'(k5 ? BIG_K - 1 : SMALL_K - 1));
		c_diff   = c_cur - CW'(k5 ? BIG_K / 2 : SMALL_K / 2);
		r_diff   = r_cur - RW'(k5 ? BIG_K / 2 : SMALL_K / 2);
		ccol_ext = (CW + POS_W)'(c_diff);
		crow_ext = (RW + POS_W)'(r_diff);
		fend     = (WW'(c_cur) == w - WW'(1)) && (HW'(r_cur) == h - HW'(1));
		c_next   = WW'(c_cur) + WW'(1);
		r_next   = HW'(r_cur) + HW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
			hit_s1     <= 1'b0;
		end else begin
			if (accept) begin
				if (c_next >= w) begin
					col_q <= '0;
					row_q <= (r_next >= h) ? '0 : RW'(r_next);
				end else begin
					col_q <= CW'(c_next);
					row_q <= r_cur;
				end
				// same column still being written by the item ahead
				hit_s1 <= s1_go && (col_s1 == c_cur);
			end else if (s1_go) begin
				hit_s1 <= 1'b0;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_s1  <= hist_new;
			px_s1   <= pixel.pixel_in;
			col_s1  <= c_cur;
			k5_s1   <= k5;
			emit_s1 <= emit;
			ccol_s1 <= ccol_ext[POS_W-1:0];
			crow_s1 <= crow_ext[POS_W-1:0];
			fend_s1 <= fend;
		end
	end

	// line store, one word of all stored rows per column
	always_ff @(posedge clk) begin
		if (s1_go) begin
			line_mem[col_s1] <= hist_new;
		end
		if (accept) begin
			rd_s1 <= line_mem[c_cur];
		end
	end

	always_comb begin
		hist     = hit_s1 ? fwd_s1 : rd_s1;
		hist_new = {hist[LS_W-PIX_W-1:0], px_s1};
		cs3 = CS_W'(px_s1) + CS_W'(hist[PIX_W-1:0]) + CS_W'(hist[2*PIX_W-1:PIX_W]);
		csm = CS_W'(px_s1);
		for (int j = 0; j < HIST; j++) begin
			csm = csm + CS_W'(hist[j*PIX_W +: PIX_W]);
		end
	end

	assign mid_push            = s1_go;
	assign mid_item.sum3       = cs3;
	assign mid_item.sum_max    = csm;
	assign mid_item.k5         = k5_s1;
	assign mid_item.emit       = emit_s1;
	assign mid_item.centre_col = ccol_s1;
	assign mid_item.centre_row = crow_s1;
	assign mid_item.frame_end  = fend_s1;

`ifndef SYNTHESIS
	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s1 |-> s1_valid_q)
		else $error("line forward flag set without an item in stage one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_go |=> s1_valid_q && $stable(col_s1))
		else $error("stalled stage one item lost or changed");
`endif

endmodule

// ===== hw/rtl/bbw_back.sv =====
// back end: column sum windows, window sum and division by the box area
// depends on bbw_pkg

module bbw_back import bbw_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mid_empty,
	input  col_item_t        mid_item,
	output logic             mid_pop,
	input  logic [LVL_W-1:0] out_level,
	output logic             out_push,
	output result_t          out_item
);

	localparam int CRD_W  = LVL_W + 1;
	localparam int PROD_W = SUM_W + RECIP_W;

	logic [CS_W-1:0]  win3_q [SMALL_K];
	logic [CS_W-1:0]  winm_q [MAX_WINDOW];
	logic [CRD_W-1:0] credit;

	logic             em_b1;
	logic             k5_b1;
	logic [POS_W-1:0] ccol_b1;
	logic [POS_W-1:0] crow_b1;
	logic             fend_b1;
	logic [SUM_W-1:0] sum3;
	logic [SUM_W-1:0] summ;

	logic             em_b2;
	logic             k5_b2;
	logic [POS_W-1:0] ccol_b2;
	logic [POS_W-1:0] crow_b2;
	logic             fend_b2;
	logic [SUM_W-1:0] sum_b2;
	logic [PROD_W-1:0] prod;

	// results in flight must fit in the output queue
	assign credit  = CRD_W'(out_level) + CRD_W'(em_b1) + CRD_W'(em_b2);
	assign mid_pop = !mid_empty && (credit < CRD_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMALL_K; i++) begin
				win3_q[i] <= '0;
			end
			for (int i = 0; i < MAX_WINDOW; i++) begin
				winm_q[i] <= '0;
			end
			em_b1 <= 1'b0;
			em_b2 <= 1'b0;
		end else begin
			if (mid_pop) begin
				win3_q[0] <= mid_item.sum3;
				for (int i = 1; i < SMALL_K; i++) begin
					win3_q[i] <= win3_q[i-1];
				end
				winm_q[0] <= mid_item.sum_max;
				for (int i = 1; i < MAX_WINDOW; i++) begin
					winm_q[i] <= winm_q[i-1];
				end
			end
			em_b1 <= mid_pop && mid_item.emit;
			em_b2 <= em_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			k5_b1   <= mid_item.k5;
			ccol_b1 <= mid_item.centre_col;
			crow_b1 <= mid_item.centre_row;
			fend_b1 <= mid_item.frame_end;
		end
		k5_b2   <= k5_b1;
		ccol_b2 <= ccol_b1;
		crow_b2 <= crow_b1;
		fend_b2 <= fend_b1;
		sum_b2  <= k5_b1 ? summ : sum3;
	end

	always_comb begin
		sum3 = '0;
		for (int i = 0; i < SMALL_K; i++) begin
			sum3 = sum3 + SUM_W'(win3_q[i]);
		end
		summ = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			summ = summ + SUM_W'(winm_q[i]);
		end
	end

	assign prod = PROD_W'(sum_b2) * PROD_W'(k5_b2 ? RECIP25 : RECIP9);

	assign out_push            = em_b2;
	assign out_item.blurred    = prod[RECIP_SHIFT +: PIX_W];
	assign out_item.centre_col = ccol_b2;
	assign out_item.centre_row = crow_b2;
	assign out_item.frame_end  = fend_b2;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit <= CRD_W'(OUT_DEPTH))
		else $error("more results in flight than output queue space");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_level < LVL_W'(OUT_DEPTH))
		else $error("result pushed into a full output queue");
`endif

endmodule
